// File: design/vslr_pkg.sv
`default_nettype none
package vslr_pkg;
    localparam int SAMPLE_W      = 16;
    localparam int STEP_W        = 21;
    localparam int CHAN_W        = 2;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = STEP_W;
    localparam int FRAC_BITS_DEF = 16;
    // position holds up to just under 17.0, so five integer bits
    localparam int POS_INT_BITS  = 5;
    localparam int MAX_OUT       = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int TDATA_W       = 2 * SAMPLE_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STEP     = 1'b0,
        REG_CHANNELS = 1'b1
    } cfg_reg_t;

    localparam logic [CHAN_W-1:0] CHAN_MONO = 2'd1;
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

    // handshake between queue and the output sequencer
    typedef struct packed {
        logic valid;
    } q_ctrl_t;
endpackage
`default_nettype wire

// File: design/variable_speed_linear_resampler.sv
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | s_tdata: left_in[15:0], right_in[31:16]
// m_      | out | m_tvalid/m_tready | m_tdata: left_out, right_out; m_tlast: last
// cfg_    | in  | cfg_wr_en         | cfg_index 0 step, 1 channels; cfg_data
//
// The output sequencer emits one result per cycle while m_tready does not hold it:
// an item pops with its last result (at most 8), or without one if it yields none.
// Results pass the product stage, then the output register, after issue.
// A two-entry queue ahead of the sequencer keeps accepting items meanwhile.
// Reset is synchronous; the first item after reset seeds the previous frame.
// m_tready low freezes the sequencer and product stage; the queue still fills.
`default_nettype none
module variable_speed_linear_resampler #(
    parameter int FRAC_BITS = vslr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [vslr_pkg::TDATA_W-1:0]     s_tdata,    // left_in, right_in
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [vslr_pkg::TDATA_W-1:0]          m_tdata,    // left_out, right_out
    output logic                                  m_tlast,
    input  wire logic                             cfg_wr_en,
    input  wire logic [vslr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [vslr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vslr_pkg::*;

    localparam int PW = FRAC_BITS + POS_INT_BITS;
    localparam int DW = 2 * SAMPLE_W + 2 * PW + 1;

    logic [STEP_W-1:0] step_reg;
    logic [CHAN_W-1:0] channels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_RESET;
            channels_reg <= CHAN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEP:     step_reg     <= cfg_data[STEP_W-1:0];
                REG_CHANNELS: channels_reg <= cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DW-1:0]       front_item, head_item;
    q_ctrl_t             head_ctrl;
    logic                head_pop;
    logic [SAMPLE_W-1:0] left_out, right_out;

    vslr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .left_in      (s_tdata[SAMPLE_W-1:0]),
        .right_in     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .step_cfg     (step_reg),
        .channels_cfg (channels_reg),
        .item_data    (front_item)
    );

    vslr_queue #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_valid    (s_tvalid),
        .wr_ready    (s_tready),
        .wr_data     (front_item),
        .rd_ctrl_out (head_ctrl),
        .rd_pop      (head_pop),
        .rd_data     (head_item)
    );

    vslr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_ctrl (head_ctrl),
        .head_data (head_item),
        .head_pop  (head_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .left_out  (left_out),
        .right_out (right_out),
        .last_out  (m_tlast)
    );

    assign m_tdata = {right_out, left_out};
endmodule
`default_nettype wire

// File: design/vslr_front.sv
`default_nettype none
module vslr_front #(
    parameter int FRAC_BITS = vslr_pkg::FRAC_BITS_DEF
) (
    input  wire logic [vslr_pkg::SAMPLE_W-1:0] left_in,
    input  wire logic [vslr_pkg::SAMPLE_W-1:0] right_in,
    input  wire logic [vslr_pkg::STEP_W-1:0]   step_cfg,
    input  wire logic [vslr_pkg::CHAN_W-1:0]   channels_cfg,
    // {mono, init_pos, step, right, left}
    output logic [2*vslr_pkg::SAMPLE_W+2*(FRAC_BITS+vslr_pkg::POS_INT_BITS):0] item_data
);
    import vslr_pkg::*;

    localparam int PW = FRAC_BITS + POS_INT_BITS;
    localparam int CW = (STEP_W > PW) ? STEP_W : PW;
    localparam logic [CW-1:0] STEP_MIN = {{(CW-1){1'b0}}, 1'b1} << (FRAC_BITS - 3);
    localparam logic [CW-1:0] STEP_MAX = {{(CW-1){1'b0}}, 1'b1} << (FRAC_BITS + 4);
    localparam logic [PW-1:0] ONE      = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [CW-1:0] step_ext;
    logic [CW-1:0] step_clamp;
    logic [PW-1:0] step_eff;
    logic [PW-1:0] init_pos;
    logic          mono;

    always_comb begin
        step_ext = CW'(step_cfg);
        if (step_ext < STEP_MIN) begin
            step_clamp = STEP_MIN;
        end else if (step_ext > STEP_MAX) begin
            step_clamp = STEP_MAX;
        end else begin
            step_clamp = step_ext;
        end
        step_eff = PW'(step_clamp);
        // start half a step in when upsampling
        init_pos = (step_eff < ONE) ? (step_eff >> 1) : '0;
        mono     = (channels_cfg == CHAN_MONO);
        item_data = {mono, init_pos, step_eff, right_in, left_in};
    end
endmodule
`default_nettype wire

// File: design/vslr_queue.sv
`default_nettype none
module vslr_queue #(
    parameter int DW    = 32,
    parameter int DEPTH = vslr_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire logic [DW-1:0] wr_data,
    output vslr_pkg::q_ctrl_t  rd_ctrl_out,
    input  wire logic          rd_pop,
    output logic [DW-1:0]      rd_data
);
    import vslr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DW-1:0]    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign wr_ready          = (count_reg != CNT_W'(DEPTH));
    assign rd_ctrl_out.valid = (count_reg != '0);
    assign rd_data           = entry_reg[rd_ptr_reg];
    assign push              = wr_valid && wr_ready;
    assign pop               = rd_pop && rd_ctrl_out.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

// File: design/vslr_back.sv
`default_nettype none
module vslr_back #(
    parameter int FRAC_BITS = vslr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire vslr_pkg::q_ctrl_t         head_ctrl,
    input  wire logic [2*vslr_pkg::SAMPLE_W+2*(FRAC_BITS+vslr_pkg::POS_INT_BITS):0] head_data,
    output logic                           head_pop,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [vslr_pkg::SAMPLE_W-1:0]  left_out,
    output logic [vslr_pkg::SAMPLE_W-1:0]  right_out,
    output logic                           last_out
);
    import vslr_pkg::*;

    localparam int PW    = FRAC_BITS + POS_INT_BITS;
    localparam int DIF_W = SAMPLE_W + 1;
    localparam int PRD_W = DIF_W + FRAC_BITS + 1;
    localparam int ACC_W = SAMPLE_W + FRAC_BITS + 2;
    localparam int CNT_W = $clog2(MAX_OUT);
    localparam logic [PW-1:0] ONE = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic [SAMPLE_W-1:0] cur_l, cur_r;
    logic [PW-1:0]       step_eff, init_pos;
    logic                mono;

    assign {mono, init_pos, step_eff, cur_r, cur_l} = head_data;

    logic                started_reg, started_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [SAMPLE_W-1:0] prev_l_reg, prev_l_next, prev_r_reg, prev_r_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [PW-1:0]       pos_eff, pos_sum;
    logic [SAMPLE_W-1:0] prev_l_eff, prev_r_eff;
    logic                adv, fire, emit, last;

    // whole output pipe moves together; held while the result is not taken
    assign adv  = !out_valid || out_ready;
    assign fire = head_ctrl.valid && adv;

    always_comb begin
        pos_eff    = started_reg ? pos_reg : init_pos;
        prev_l_eff = started_reg ? prev_l_reg : cur_l;
        prev_r_eff = started_reg ? prev_r_reg : cur_r;
        pos_sum    = pos_eff + step_eff;
        emit       = (pos_eff < ONE);
        last       = (pos_sum >= ONE) || (cnt_reg == CNT_W'(MAX_OUT - 1));
        head_pop   = fire && (!emit || last);

        started_next = started_reg || fire;
        pos_next     = pos_reg;
        prev_l_next  = prev_l_reg;
        prev_r_next  = prev_r_reg;
        cnt_next     = cnt_reg;
        if (fire) begin
            if (!emit) begin
                pos_next = pos_eff - ONE;
            end else if (last) begin
                pos_next = (pos_sum >= ONE) ? pos_sum - ONE : '0;
            end else begin
                pos_next = pos_sum;
            end
            prev_l_next = head_pop ? cur_l : prev_l_eff;
            prev_r_next = head_pop ? cur_r : prev_r_eff;
            cnt_next    = head_pop ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        prev_l_reg <= prev_l_next;
        prev_r_reg <= prev_r_next;
    end

    // stage 1: (cur - prev) * frac per channel
    logic                    s1_valid_reg;
    logic                    s1_last_reg, s1_mono_reg;
    logic [SAMPLE_W-1:0]     s1_prev_l_reg, s1_prev_r_reg;
    logic signed [PRD_W-1:0] s1_prod_l_reg, s1_prod_r_reg;
    logic signed [DIF_W-1:0] diff_l, diff_r;
    logic signed [FRAC_BITS:0] frac_s;

    assign diff_l = $signed({cur_l[SAMPLE_W-1], cur_l})
                  - $signed({prev_l_eff[SAMPLE_W-1], prev_l_eff});
    assign diff_r = $signed({cur_r[SAMPLE_W-1], cur_r})
                  - $signed({prev_r_eff[SAMPLE_W-1], prev_r_eff});
    assign frac_s = $signed({1'b0, pos_eff[FRAC_BITS-1:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_last_reg   <= last;
            s1_mono_reg   <= mono;
            s1_prev_l_reg <= prev_l_eff;
            s1_prev_r_reg <= prev_r_eff;
            s1_prod_l_reg <= diff_l * frac_s;
            s1_prod_r_reg <= diff_r * frac_s;
        end
    end

    // stage 2: prev * 1.0 + product, round half up, into the output register
    logic signed [ACC_W-1:0] acc_l, acc_r;

    assign acc_l = $signed({{2{s1_prev_l_reg[SAMPLE_W-1]}}, s1_prev_l_reg,
                            {FRAC_BITS{1'b0}}})
                 + ACC_W'(s1_prod_l_reg) + HALF;
    assign acc_r = $signed({{2{s1_prev_r_reg[SAMPLE_W-1]}}, s1_prev_r_reg,
                            {FRAC_BITS{1'b0}}})
                 + ACC_W'(s1_prod_r_reg) + HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (adv) begin
            out_valid <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            left_out  <= acc_l[FRAC_BITS +: SAMPLE_W];
            right_out <= s1_mono_reg ? '0 : acc_r[FRAC_BITS +: SAMPLE_W];
            last_out  <= s1_last_reg;
        end
    end
endmodule
`default_nettype wire

// File: design/vslr_checker.sv
`default_nettype none
module vslr_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [vslr_pkg::TDATA_W-1:0]     m_tdata,
    input wire logic                             m_tlast,
    input wire logic                             cfg_wr_en,
    input wire logic [vslr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input wire logic [vslr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vslr_pkg::*;

    localparam int CNT_W = $clog2(MAX_OUT);

    logic             mono_reg, mono_next;
    logic [CNT_W-1:0] run_reg, run_next;

    always_comb begin
        mono_next = mono_reg;
        if (cfg_wr_en && cfg_index == REG_CHANNELS) begin
            mono_next = (cfg_data[CHAN_W-1:0] == CHAN_MONO);
        end
        run_next = run_reg;
        if (m_tvalid && m_tready) begin
            run_next = m_tlast ? '0 : run_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mono_reg <= 1'b0;
            run_reg  <= '0;
        end else begin
            mono_reg <= mono_next;
            run_reg  <= run_next;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_mono_right: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mono_reg |-> m_tdata[TDATA_W-1:SAMPLE_W] == '0)
        else $error("right channel nonzero in mono");

    a_run_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && run_reg == CNT_W'(MAX_OUT - 1) |-> m_tlast)
        else $error("more than the maximum results for one item");
endmodule

bind variable_speed_linear_resampler vslr_checker u_vslr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import vslr_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam longint ONE    = longint'(1) << FRAC;
    localparam longint STEP_FLOOR = ONE >> 3;
    localparam longint STEP_CEIL  = ONE << 4;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 56;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } out_frame_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata   = '0;    // left_in, right_in
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [TDATA_W-1:0]     m_tdata;           // left_out, right_out
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_STEP;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor state
    logic [STEP_W-1:0]          step_cfg = STEP_RESET;
    logic [CHAN_W-1:0]          chan_cfg = CHAN_RESET;
    logic signed [SAMPLE_W-1:0] prev_left  = '0;
    logic signed [SAMPLE_W-1:0] prev_right = '0;
    longint                     read_pos   = 0;
    bit                         seeded     = 1'b0;

    out_frame_t expected_frames[$];
    int  error_count  = 0;
    int  frames_in    = 0;
    int  frames_out   = 0;
    int  cfg_settings = 0;
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    bit  hold_ready   = 1'b0;
    int  quiet_cycles = 0;

    variable_speed_linear_resampler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        error_count++;
    endtask

    // prev*(1-f) + cur*f, rounded half up
    function automatic logic signed [SAMPLE_W-1:0] blend(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input longint                     f
    );
        longint acc;
        acc = longint'(a) * (ONE - f) + longint'(b) * f;
        acc = (acc + (ONE >> 1)) >>> FRAC;
        return acc[SAMPLE_W-1:0];
    endfunction

    task automatic interpolate_frame(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r
    );
        longint     st;
        int         n;
        out_frame_t res;
        st = longint'(step_cfg);
        if (st < STEP_FLOOR) st = STEP_FLOOR;
        if (st > STEP_CEIL) st = STEP_CEIL;
        if (!seeded) begin
            prev_left  = l;
            prev_right = r;
            seeded     = 1'b1;
            read_pos   = (st < ONE) ? (st >> 1) : 0;
        end
        n = 0;
        while (read_pos < ONE && n < MAX_OUT) begin
            res.left  = blend(prev_left, l, read_pos);
            res.right = (chan_cfg == CHAN_MONO) ? '0 : blend(prev_right, r, read_pos);
            read_pos += st;
            n++;
            res.last  = !(read_pos < ONE && n < MAX_OUT);
            expected_frames.push_back(res);
        end
        read_pos   = (read_pos >= ONE) ? read_pos - ONE : 0;
        prev_left  = l;
        prev_right = r;
    endtask

    task automatic send_frame(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r
    );
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        interpolate_frame(l, r);
        frames_in++;
    endtask

    // sender holds off until every pending result is out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_frames.size() != 0) @(posedge aclk);
    endtask

    // frames that yield nothing may still be in flight once the queue is empty
    task automatic reconfigure(input logic [STEP_W-1:0] stp, input logic [CHAN_W-1:0] ch);
        hold_ready = 1'b1;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_STEP;
        cfg_data  <= stp;
        @(posedge aclk);
        step_cfg = stp;
        cfg_index <= REG_CHANNELS;
        cfg_data  <= CFG_DATA_W'(ch);
        @(posedge aclk);
        chan_cfg = ch;
        cfg_wr_en <= 1'b0;
        hold_ready = 1'b0;
        cfg_settings++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
        input logic signed [SAMPLE_W-1:0] last_val
    );
        int t;
        case ($urandom_range(9))
            0, 1, 2, 3: return SAMPLE_W'($urandom);
            4, 5:       return SAMPLE_W'(int'($urandom_range(6)) - 3);
            6: begin
                case ($urandom_range(3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            default: begin
                // smooth signal, small step from the previous sample
                t = int'(last_val) + int'($urandom_range(2000)) - 1000;
                if (t > 32767) t = 32767;
                if (t < -32768) t = -32768;
                return SAMPLE_W'(t);
            end
        endcase
    endfunction

    task automatic test_first_frame();
        // half step: first position is a quarter
        reconfigure(21'h08000, 2'd2);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh0000, 16'sh0000);
    endtask

    task automatic test_rounding_ties();
        // eighth step gives positions at odd sixteenths; channel code 3 acts as stereo
        reconfigure(21'd8192, 2'd3);
        send_frame(16'sh0001, -16'sh0001);
        send_frame(16'sh0000, 16'sh0000);
        send_frame(-16'sh0001, 16'sh0002);
        send_frame(16'sh0001, -16'sh0002);
    endtask

    task automatic test_mono();
        reconfigure(21'h0C000, CHAN_MONO);
        send_frame(16'sh3039, -16'sh0007);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh7FFF, 16'sh8000);
        // channel code 0 acts as stereo
        reconfigure(21'h10000, 2'd0);
        send_frame(16'sh1234, 16'sh8000);
        send_frame(-16'sh1234, 16'sh7FFF);
    endtask

    task automatic test_step_limits();
        reconfigure(21'd0, 2'd2);
        send_frame(16'sh4000, -16'sh4000);
        send_frame(-16'sh4000, 16'sh4000);
        reconfigure(21'd8191, 2'd2);
        send_frame(16'sh7FFF, 16'sh7FFF);
        reconfigure(21'h1FFFFF, 2'd2);
        send_frame(16'sh0100, 16'sh0200);
        send_frame(16'sh0300, 16'sh0400);
        send_frame(16'sh0500, 16'sh0600);
        reconfigure(21'd1048576, 2'd1);
        send_frame(16'sh8000, 16'sh0001);
        send_frame(16'sh7FFF, 16'sh0002);
        reconfigure(21'd1048577, 2'd2);
        send_frame(16'sh0010, 16'sh0020);
        // 2.5: frames with and without results
        reconfigure(21'h28000, 2'd2);
        send_frame(16'sh1000, 16'sh2000);
        send_frame(16'sh3000, 16'sh4000);
        send_frame(16'sh5000, 16'sh6000);
    endtask

    task automatic test_random_stream();
        logic [STEP_W-1:0]          stp;
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        int                         pick;
        l = '0;
        r = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick = $urandom_range(9);
            if (pick < 6)      stp = STEP_W'($urandom_range(32'h20000, 8192));
            else if (pick < 8) stp = STEP_W'($urandom_range(1048576, 32'h20000));
            else if (pick < 9) stp = STEP_W'($urandom_range(8191, 0));
            else               stp = STEP_W'($urandom_range(32'h1FFFFF, 1048577));
            reconfigure(stp, CHAN_W'($urandom_range(3)));
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
                default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                l = pick_sample(l);
                r = pick_sample(r);
                send_frame(l, r);
                if ($urandom_range(39) == 0) drain_results();
            end
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    always @(posedge aclk) begin
        if (hold_ready || rx_stall_pct == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_frame_t exp_f;
        logic signed [SAMPLE_W-1:0] got_l;
        logic signed [SAMPLE_W-1:0] got_r;
        if (aresetn && m_tvalid && m_tready) begin
            got_l = m_tdata[SAMPLE_W-1:0];
            got_r = m_tdata[2*SAMPLE_W-1:SAMPLE_W];
            frames_out++;
            if (expected_frames.size() == 0) begin
                report_mismatch($sformatf("unexpected result L=%0d R=%0d last=%0b",
                                          got_l, got_r, m_tlast));
            end else begin
                exp_f = expected_frames.pop_front();
                if (got_l !== exp_f.left)
                    report_mismatch($sformatf("result %0d left: expected %0d, got %0d",
                                              frames_out, exp_f.left, got_l));
                if (got_r !== exp_f.right)
                    report_mismatch($sformatf("result %0d right: expected %0d, got %0d",
                                              frames_out, exp_f.right, got_r));
                if (m_tlast !== exp_f.last)
                    report_mismatch($sformatf("result %0d last: expected %0b, got %0b",
                                              frames_out, exp_f.last, m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_frames.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_frame();
        test_rounding_ties();
        test_mono();
        test_step_limits();
        test_random_stream();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d frames, checked %0d interpolated frames over %0d step/channel",
                 frames_in, frames_out, cfg_settings);
        $display("settings, including clamped steps, mono and all idling mixes");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
